// ===== rtl/core/phi_pkg.sv =====
// shared types, constants and helper functions for the pointing history interpolator
// no dependencies; imported by every module of the block but phi_div
`default_nettype none
package phi_pkg;

  localparam int HISTORY_DEPTH_DEF = 16;
  localparam int CORDIC_STEPS_DEF  = 32;

  // step counts of the shared iterative units
  localparam int CNT_W     = 7;
  localparam int DIV_STEPS = 64;
  localparam int RT_STEPS  = 32;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;
  localparam logic signed [35:0] ONE_Q30     = 36'sh040000000;

  // datapath operation codes
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
  localparam logic [OP_W-1:0] OP_CINIT_RA  = 5'd2;
  localparam logic [OP_W-1:0] OP_CINIT_DEC = 5'd3;
  localparam logic [OP_W-1:0] OP_CSTEP     = 5'd4;
  localparam logic [OP_W-1:0] OP_CSAVE_RA  = 5'd5;
  localparam logic [OP_W-1:0] OP_CSAVE_DEC = 5'd6;
  localparam logic [OP_W-1:0] OP_MUL_X     = 5'd7;
  localparam logic [OP_W-1:0] OP_MUL_Y     = 5'd8;
  localparam logic [OP_W-1:0] OP_MUL_END   = 5'd9;
  localparam logic [OP_W-1:0] OP_WRITE     = 5'd10;
  localparam logic [OP_W-1:0] OP_QSTART    = 5'd11;
  localparam logic [OP_W-1:0] OP_QCUR      = 5'd12;
  localparam logic [OP_W-1:0] OP_QADV      = 5'd13;
  localparam logic [OP_W-1:0] OP_RES_CUR   = 5'd14;
  localparam logic [OP_W-1:0] OP_BSETUP    = 5'd15;
  localparam logic [OP_W-1:0] OP_BSHIFT    = 5'd16;
  localparam logic [OP_W-1:0] OP_FDIV_INIT = 5'd17;
  localparam logic [OP_W-1:0] OP_DIV_STEP  = 5'd18;
  localparam logic [OP_W-1:0] OP_FRAC_SAVE = 5'd19;
  localparam logic [OP_W-1:0] OP_BMUL_A    = 5'd20;
  localparam logic [OP_W-1:0] OP_BMUL_B    = 5'd21;
  localparam logic [OP_W-1:0] OP_BMUL_C    = 5'd22;
  localparam logic [OP_W-1:0] OP_SQ_M      = 5'd23;
  localparam logic [OP_W-1:0] OP_SQ_A      = 5'd24;
  localparam logic [OP_W-1:0] OP_RT_INIT   = 5'd25;
  localparam logic [OP_W-1:0] OP_RT_STEP   = 5'd26;
  localparam logic [OP_W-1:0] OP_NDIV_INIT = 5'd27;
  localparam logic [OP_W-1:0] OP_NSAVE     = 5'd28;
  localparam logic [OP_W-1:0] OP_OUT       = 5'd29;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [CNT_W-1:0] cnt;
    logic [1:0]       k;
  } phi_cmd_t;

  typedef struct packed {
    logic hist_empty;
    logic pp_valid;
    logic pp_is_newest;
    logic bracket;
    logic t_equal;
    logic span_big;
    logic sq_zero;
    logic len_zero;
    logic out_free;
  } phi_stat_t;

  // arctangent of 2^-i in units of 2^32 per full circle
  function automatic logic signed [33:0] atan_entry(input logic [5:0] i);
    logic signed [33:0] v;
    case (i)
      6'd0:  v = 34'sd536870912;
      6'd1:  v = 34'sd316933406;
      6'd2:  v = 34'sd167458907;
      6'd3:  v = 34'sd85004756;
      6'd4:  v = 34'sd42667331;
      6'd5:  v = 34'sd21354465;
      6'd6:  v = 34'sd10679838;
      6'd7:  v = 34'sd5340245;
      6'd8:  v = 34'sd2670163;
      6'd9:  v = 34'sd1335087;
      6'd10: v = 34'sd667544;
      6'd11: v = 34'sd333772;
      6'd12: v = 34'sd166886;
      6'd13: v = 34'sd83443;
      6'd14: v = 34'sd41722;
      6'd15: v = 34'sd20861;
      6'd16: v = 34'sd10430;
      6'd17: v = 34'sd5215;
      6'd18: v = 34'sd2608;
      6'd19: v = 34'sd1304;
      6'd20: v = 34'sd652;
      6'd21: v = 34'sd326;
      6'd22: v = 34'sd163;
      6'd23: v = 34'sd81;
      6'd24: v = 34'sd41;
      6'd25: v = 34'sd20;
      6'd26: v = 34'sd10;
      6'd27: v = 34'sd5;
      6'd28: v = 34'sd3;
      6'd29: v = 34'sd1;
      6'd30: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  // limit a q6.30 value to [-1, 1], returned as q2.30
  function automatic logic signed [31:0] clamp_q30(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > ONE_Q30) begin
      r = 32'sh40000000;
    end else if (v < -ONE_Q30) begin
      r = -32'sh40000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/phi_div.sv =====
// iterative restoring divider, one quotient bit per step, 64-bit dividend by 32-bit divisor
// depends on nothing but its ports
`default_nettype none
module phi_div (
  input  wire logic        clk,
  input  wire logic        load,
  input  wire logic        step,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic      [63:0] quotient
);

  logic [31:0] rem;
  logic [31:0] dsr;
  logic [63:0] q;
  logic [32:0] trial;

  assign trial    = {rem, q[63]};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= '0;
      q   <= dividend;
      dsr <= divisor;
    end else if (step) begin
      if (trial >= {1'b0, dsr}) begin
        rem <= 32'(trial - {1'b0, dsr});
        q   <= {q[62:0], 1'b1};
      end else begin
        rem <= trial[31:0];
        q   <= {q[62:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/phi_dp.sv =====
// datapath: sample ring, cordic unit, shared multiplier, square root and output register
// depends on phi_pkg and phi_div
`default_nettype none
module phi_dp
  import phi_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire phi_cmd_t      cmd,
  output phi_stat_t          stat,
  input  wire logic [127:0]  s_tdata,
  input  wire logic          cfg_valid,
  input  wire logic [23:0]   cfg_data,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [95:0]        m_tdata,
  output logic               m_tuser
);

  localparam int SLOT_W = $clog2(HISTORY_DEPTH);
  localparam int ENT_W  = 159;

  logic [23:0] delay_us;
  logic [31:0] in_ra;
  logic [31:0] in_dec;
  logic [62:0] in_time;

  // sample ring
  logic [ENT_W-1:0]         mem [HISTORY_DEPTH];
  logic [ENT_W-1:0]         rdata;
  logic [HISTORY_DEPTH-1:0] valid;
  logic [SLOT_W-1:0]        newest;
  logic [SLOT_W-1:0]        p;
  logic [SLOT_W-1:0]        prev_p;
  logic [SLOT_W-1:0]        prev_pp;
  logic [SLOT_W-1:0]        next_n;
  logic [SLOT_W-1:0]        rd_addr;
  logic                     rd_en;
  logic                     wr_en;

  // cordic
  logic signed [33:0] cx, cy, cz;
  logic               cflip;
  logic signed [33:0] shx, shy, atv;
  logic [31:0]        cin;
  logic [31:0]        csum;
  logic               cfl;
  logic [31:0]        cin2;
  logic signed [31:0] xc, yc;
  logic signed [31:0] cr, sr, cd, sd;
  logic signed [31:0] vx, vy;

  // shared multiplier and blend
  logic signed [65:0] prod;
  logic signed [65:0] acc;
  logic signed [63:0] msum;
  logic signed [66:0] bsum;
  logic signed [63:0] now;
  logic [62:0]        cur_t;
  logic [2:0][31:0]   cur_v;
  logic [2:0][31:0]   e_v;
  logic [2:0][31:0]   b_v;
  logic [2:0][31:0]   res_v;
  logic               res_present;
  logic [62:0]        span;
  logic [62:0]        wgt;
  logic [32:0]        frac;
  logic [32:0]        wfrac;
  logic [63:0]        sq;

  // square root
  logic [63:0] rt_n, rt_r, rt_bit, rt_sum;

  // normalizing divide
  logic [31:0]        babs;
  logic [63:0]        div_dividend;
  logic [31:0]        div_divisor;
  logic [63:0]        div_q;
  logic [31:0]        qc;
  logic               div_load;

  logic [62:0] rd_t;
  logic [2:0][31:0] rd_v;

  assign rd_t = rdata[62:0];
  assign rd_v = rdata[158:63];

  assign prev_p  = (p == '0) ? SLOT_W'(HISTORY_DEPTH - 1) : SLOT_W'(p - 1'b1);
  assign prev_pp = (prev_p == '0) ? SLOT_W'(HISTORY_DEPTH - 1) : SLOT_W'(prev_p - 1'b1);
  assign next_n  = (newest == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : SLOT_W'(newest + 1'b1);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = newest;
    case (cmd.op)
      OP_QSTART: begin
        rd_en   = 1'b1;
        rd_addr = newest;
      end
      OP_QCUR: begin
        rd_en   = 1'b1;
        rd_addr = prev_p;
      end
      OP_QADV: begin
        rd_en   = 1'b1;
        rd_addr = prev_pp;
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = newest;
      end
    endcase
  end

  assign wr_en = (cmd.op == OP_WRITE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[next_n] <= {sd, vy, vx, in_time};
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      newest   <= '0;
      delay_us <= 24'd1;
    end else begin
      if (cfg_valid) begin
        delay_us <= cfg_data;
      end
      if (wr_en) begin
        valid[next_n] <= 1'b1;
        newest        <= next_n;
      end
    end
  end

  // cordic helpers
  assign cin  = (cmd.op == OP_CINIT_DEC) ? in_dec : in_ra;
  assign csum = cin + 32'h4000_0000;
  assign cfl  = csum[31];
  assign cin2 = cfl ? (cin ^ 32'h8000_0000) : cin;
  assign shx  = cx >>> cmd.cnt;
  assign shy  = cy >>> cmd.cnt;
  assign atv  = atan_entry(cmd.cnt[5:0]);
  assign xc   = clamp_q30({{2{cx[33]}}, cx});
  assign yc   = clamp_q30({{2{cy[33]}}, cy});

  assign msum  = prod[63:0] + 64'sh2000_0000;
  assign bsum  = {acc[65], acc} + {prod[65], prod} + 67'sh0_8000_0000;
  assign wfrac = 33'h1_0000_0000 - frac;
  assign rt_sum = rt_r + rt_bit;

  assign babs = b_v[cmd.k][31] ? 32'(-b_v[cmd.k]) : b_v[cmd.k];
  assign qc   = (div_q > 64'h4000_0000) ? 32'h4000_0000 : div_q[31:0];

  always_comb begin
    if (cmd.op == OP_FDIV_INIT) begin
      div_dividend = {wgt[31:0], 32'h0};
      div_divisor  = span[31:0];
    end else begin
      div_dividend = ({32'h0, babs} << 30) + {33'h0, rt_r[31:1]};
      div_divisor  = rt_r[31:0];
    end
  end

  assign div_load = (cmd.op == OP_FDIV_INIT) || (cmd.op == OP_NDIV_INIT);

  phi_div u_div (
    .clk      (clk),
    .load     (div_load),
    .step     (cmd.op == OP_DIV_STEP),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        in_ra   <= s_tdata[31:0];
        in_dec  <= s_tdata[63:32];
        in_time <= s_tdata[126:64];
      end
      OP_CINIT_RA, OP_CINIT_DEC: begin
        cx    <= CORDIC_GAIN;
        cy    <= '0;
        cz    <= {{2{cin2[31]}}, cin2};
        cflip <= cfl;
      end
      OP_CSTEP: begin
        if (!cz[33]) begin
          cx <= cx - shy;
          cy <= cy + shx;
          cz <= cz - atv;
        end else begin
          cx <= cx + shy;
          cy <= cy - shx;
          cz <= cz + atv;
        end
      end
      OP_CSAVE_RA: begin
        cr <= cflip ? -xc : xc;
        sr <= cflip ? -yc : yc;
      end
      OP_CSAVE_DEC: begin
        cd <= cflip ? -xc : xc;
        sd <= cflip ? -yc : yc;
      end
      OP_MUL_X: begin
        prod <= cr * cd;
      end
      OP_MUL_Y: begin
        vx   <= clamp_q30({{2{msum[63]}}, msum[63:30]});
        prod <= sr * cd;
      end
      OP_MUL_END: begin
        vy <= clamp_q30({{2{msum[63]}}, msum[63:30]});
      end
      OP_QSTART: begin
        now         <= $signed({1'b0, in_time}) - $signed({40'h0, delay_us});
        p           <= newest;
        res_v       <= '0;
        res_present <= valid[newest];
      end
      OP_QCUR: begin
        cur_t <= rd_t;
        cur_v <= rd_v;
      end
      OP_QADV: begin
        p     <= prev_p;
        cur_t <= rd_t;
        cur_v <= rd_v;
      end
      OP_RES_CUR: begin
        res_v <= cur_v;
      end
      OP_BSETUP: begin
        e_v  <= rd_v;
        span <= cur_t - rd_t;
        wgt  <= 63'(now - $signed({1'b0, rd_t}));
      end
      OP_BSHIFT: begin
        span <= span >> 1;
        wgt  <= wgt >> 1;
      end
      OP_FRAC_SAVE: begin
        frac <= div_q[32:0];
        sq   <= '0;
      end
      OP_BMUL_A: begin
        prod <= $signed(cur_v[cmd.k]) * $signed({1'b0, frac});
      end
      OP_BMUL_B: begin
        acc  <= prod;
        prod <= $signed(e_v[cmd.k]) * $signed({1'b0, wfrac});
      end
      OP_BMUL_C: begin
        b_v[cmd.k] <= bsum[63:32];
      end
      OP_SQ_M: begin
        prod <= $signed(b_v[cmd.k]) * $signed(b_v[cmd.k]);
      end
      OP_SQ_A: begin
        sq <= sq + prod[63:0];
      end
      OP_RT_INIT: begin
        rt_n   <= sq;
        rt_r   <= '0;
        rt_bit <= 64'h4000_0000_0000_0000;
      end
      OP_RT_STEP: begin
        if (rt_n >= rt_sum) begin
          rt_n <= rt_n - rt_sum;
          rt_r <= (rt_r >> 1) + rt_bit;
        end else begin
          rt_r <= rt_r >> 1;
        end
        rt_bit <= rt_bit >> 2;
      end
      OP_NSAVE: begin
        res_v[cmd.k] <= b_v[cmd.k][31] ? 32'(-qc) : qc;
      end
      default: begin
      end
    endcase
  end

  // output register, loaded only when empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      m_tdata <= res_v;
      m_tuser <= res_present;
    end
  end

  assign stat.hist_empty   = !valid[newest];
  assign stat.pp_valid     = valid[prev_p];
  assign stat.pp_is_newest = (prev_p == newest);
  assign stat.bracket      = ($signed({1'b0, rd_t}) <= now) && (now <= $signed({1'b0, cur_t}));
  assign stat.t_equal      = (rd_t == cur_t);
  assign stat.span_big     = |span[62:32];
  assign stat.sq_zero      = (sq == '0);
  assign stat.len_zero     = (rt_r[31:0] == '0);
  assign stat.out_free     = !m_tvalid || m_tready;

endmodule
`default_nettype wire

// ===== rtl/core/phi_ctrl.sv =====
// controller state machine: sequences record and query work on the datapath
// depends on phi_pkg
`default_nettype none
module phi_ctrl
  import phi_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  input  wire logic      s_tuser,
  output logic           s_tready,
  input  wire phi_stat_t stat,
  output phi_cmd_t       cmd
);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_CRA_INIT  = 5'd1;
  localparam logic [4:0] S_CRA_STEP  = 5'd2;
  localparam logic [4:0] S_CRA_SAVE  = 5'd3;
  localparam logic [4:0] S_CDEC_INIT = 5'd4;
  localparam logic [4:0] S_CDEC_STEP = 5'd5;
  localparam logic [4:0] S_CDEC_SAVE = 5'd6;
  localparam logic [4:0] S_MUL_X     = 5'd7;
  localparam logic [4:0] S_MUL_Y     = 5'd8;
  localparam logic [4:0] S_MUL_END   = 5'd9;
  localparam logic [4:0] S_WRITE     = 5'd10;
  localparam logic [4:0] S_Q_START   = 5'd11;
  localparam logic [4:0] S_Q_CUR     = 5'd12;
  localparam logic [4:0] S_Q_PREV    = 5'd13;
  localparam logic [4:0] S_RES_CUR   = 5'd14;
  localparam logic [4:0] S_B_SETUP   = 5'd15;
  localparam logic [4:0] S_B_SHIFT   = 5'd16;
  localparam logic [4:0] S_F_INIT    = 5'd17;
  localparam logic [4:0] S_F_DIV     = 5'd18;
  localparam logic [4:0] S_F_SAVE    = 5'd19;
  localparam logic [4:0] S_BM_A      = 5'd20;
  localparam logic [4:0] S_BM_B      = 5'd21;
  localparam logic [4:0] S_BM_C      = 5'd22;
  localparam logic [4:0] S_SQ_M      = 5'd23;
  localparam logic [4:0] S_SQ_A      = 5'd24;
  localparam logic [4:0] S_RT_INIT   = 5'd25;
  localparam logic [4:0] S_RT        = 5'd26;
  localparam logic [4:0] S_N_INIT    = 5'd27;
  localparam logic [4:0] S_N_DIV     = 5'd28;
  localparam logic [4:0] S_N_SAVE    = 5'd29;
  localparam logic [4:0] S_OUT       = 5'd30;

  localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(CORDIC_STEPS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST    = CNT_W'(DIV_STEPS - 1);
  localparam logic [CNT_W-1:0] RT_LAST     = CNT_W'(RT_STEPS - 1);

  logic [4:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [1:0]       k, k_next;
  logic [OP_W-1:0]  op;

  assign s_tready = (state == S_IDLE);
  assign cmd.op   = op;
  assign cmd.cnt  = cnt;
  assign cmd.k    = k;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    k_next     = k;
    op         = OP_NONE;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          op         = OP_LOAD;
          state_next = s_tuser ? S_Q_START : S_CRA_INIT;
        end
      end
      S_CRA_INIT: begin
        op         = OP_CINIT_RA;
        cnt_next   = '0;
        state_next = S_CRA_STEP;
      end
      S_CRA_STEP: begin
        op       = OP_CSTEP;
        cnt_next = cnt + 1'b1;
        if (cnt == CORDIC_LAST) begin
          state_next = S_CRA_SAVE;
        end
      end
      S_CRA_SAVE: begin
        op         = OP_CSAVE_RA;
        state_next = S_CDEC_INIT;
      end
      S_CDEC_INIT: begin
        op         = OP_CINIT_DEC;
        cnt_next   = '0;
        state_next = S_CDEC_STEP;
      end
      S_CDEC_STEP: begin
        op       = OP_CSTEP;
        cnt_next = cnt + 1'b1;
        if (cnt == CORDIC_LAST) begin
          state_next = S_CDEC_SAVE;
        end
      end
      S_CDEC_SAVE: begin
        op         = OP_CSAVE_DEC;
        state_next = S_MUL_X;
      end
      S_MUL_X: begin
        op         = OP_MUL_X;
        state_next = S_MUL_Y;
      end
      S_MUL_Y: begin
        op         = OP_MUL_Y;
        state_next = S_MUL_END;
      end
      S_MUL_END: begin
        op         = OP_MUL_END;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        op         = OP_WRITE;
        state_next = S_IDLE;
      end
      S_Q_START: begin
        op         = OP_QSTART;
        state_next = stat.hist_empty ? S_OUT : S_Q_CUR;
      end
      S_Q_CUR: begin
        op         = OP_QCUR;
        state_next = S_Q_PREV;
      end
      S_Q_PREV: begin
        if (!stat.pp_valid) begin
          state_next = S_RES_CUR;
        end else if (stat.bracket) begin
          state_next = stat.t_equal ? S_RES_CUR : S_B_SETUP;
        end else begin
          op = OP_QADV;
          if (stat.pp_is_newest) begin
            state_next = S_RES_CUR;
          end
        end
      end
      S_RES_CUR: begin
        op         = OP_RES_CUR;
        state_next = S_OUT;
      end
      S_B_SETUP: begin
        op         = OP_BSETUP;
        state_next = S_B_SHIFT;
      end
      S_B_SHIFT: begin
        if (stat.span_big) begin
          op = OP_BSHIFT;
        end else begin
          state_next = S_F_INIT;
        end
      end
      S_F_INIT: begin
        op         = OP_FDIV_INIT;
        cnt_next   = '0;
        state_next = S_F_DIV;
      end
      S_F_DIV: begin
        op       = OP_DIV_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          state_next = S_F_SAVE;
        end
      end
      S_F_SAVE: begin
        op         = OP_FRAC_SAVE;
        k_next     = '0;
        state_next = S_BM_A;
      end
      S_BM_A: begin
        op         = OP_BMUL_A;
        state_next = S_BM_B;
      end
      S_BM_B: begin
        op         = OP_BMUL_B;
        state_next = S_BM_C;
      end
      S_BM_C: begin
        op = OP_BMUL_C;
        if (k == 2'd2) begin
          k_next     = '0;
          state_next = S_SQ_M;
        end else begin
          k_next     = k + 1'b1;
          state_next = S_BM_A;
        end
      end
      S_SQ_M: begin
        op         = OP_SQ_M;
        state_next = S_SQ_A;
      end
      S_SQ_A: begin
        op = OP_SQ_A;
        if (k == 2'd2) begin
          state_next = S_RT_INIT;
        end else begin
          k_next     = k + 1'b1;
          state_next = S_SQ_M;
        end
      end
      S_RT_INIT: begin
        if (stat.sq_zero) begin
          state_next = S_RES_CUR;
        end else begin
          op         = OP_RT_INIT;
          cnt_next   = '0;
          state_next = S_RT;
        end
      end
      S_RT: begin
        op       = OP_RT_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == RT_LAST) begin
          k_next     = '0;
          state_next = S_N_INIT;
        end
      end
      S_N_INIT: begin
        if (stat.len_zero) begin
          state_next = S_RES_CUR;
        end else begin
          op         = OP_NDIV_INIT;
          cnt_next   = '0;
          state_next = S_N_DIV;
        end
      end
      S_N_DIV: begin
        op       = OP_DIV_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          state_next = S_N_SAVE;
        end
      end
      S_N_SAVE: begin
        op = OP_NSAVE;
        if (k == 2'd2) begin
          state_next = S_OUT;
        end else begin
          k_next     = k + 1'b1;
          state_next = S_N_INIT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          op         = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      k     <= k_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pointing_history_interpolator.sv =====
// top level of the pointing history interpolator: controller plus datapath
// depends on phi_pkg, phi_ctrl, phi_dp (and phi_div below it)
//
//  channel  | direction | transfer when          | content
//  s_*      | in        | s_tvalid & s_tready    | record or query request
//  m_*      | out       | m_tvalid & m_tready    | interpolated unit vector, one per query
//  cfg_*    | in        | cfg_valid & cfg_ready  | display delay in microseconds
//
// a record runs the cordic unit on ra and then on dec, then the multiplies and the ring write
// a query walks the ring one slot per cycle (up to HISTORY_DEPTH), then a blend
// takes 64 divider steps for the weight, up to 31 span shifts, 32 root steps
// and a normalizing divide of 64 divider steps per component; ring reset needs no clearing pass
// one request is in flight at a time; s_tready is high only when the controller is idle
// a finished result waits in the output register and stalls the next result only
// reset (rst, synchronous) clears the ring valid bits, the newest slot and sets delay to 1
`default_nettype none
module pointing_history_interpolator
  import phi_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // request stream
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [127:0] s_tdata,   // ra_angle[31:0], dec_angle[63:32], time_us[126:64], zero
  input  wire logic         s_tuser,   // req_type: 0 record, 1 query
  // result stream
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [95:0]       m_tdata,   // pos_x[31:0], pos_y[63:32], pos_z[95:64]
  output logic              m_tuser,   // history_present
  // delay register write
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [23:0]  cfg_data   // display_delay_us
);

  phi_cmd_t  cmd;
  phi_stat_t stat;

  // delay writes are always taken
  assign cfg_ready = 1'b1;

  phi_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  phi_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// self-checking testbench for pointing_history_interpolator
// depends on phi_pkg and the rtl below rtl/core; carries its own ring and cordic predictor
`default_nettype none
module tb;
  import phi_pkg::*;

  localparam int RING_SLOTS   = 16;
  localparam int ROT_STEPS    = 32;
  localparam int STALL_LIMIT  = 6000;   // cycles with no transfer before giving up
  localparam int SETTLE_WAIT  = 600;    // longest query walk plus blend, rounded up
  localparam int LONG_HOLD    = 1500;   // receiver hold-off for the pressure test
  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;
  localparam logic [23:0] DELAY_MIN = 24'd1;
  localparam logic [23:0] DELAY_NOM = 24'd10000000;
  localparam logic [23:0] DELAY_MAX = 24'hFFFFFF;
  localparam longint unsigned TIME_TOP = 64'h7FFF_FFFF_FFFF_FFFE;

  // arctangent of 2^-i, 2^32 per turn
  localparam longint ARCTAN [ROT_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
    5, 3, 1, 1, 0};

  typedef longint vec3_t [3];
  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        present;
  } position_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [95:0]  m_tdata;
  logic         m_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [23:0]  cfg_data = '0;

  pointing_history_interpolator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the ring and the delay register
  longint      ring_vec [RING_SLOTS][3];
  longint      ring_time [RING_SLOTS];
  bit          ring_ok [RING_SLOTS];
  int unsigned ring_newest;
  longint      delay_us;

  position_t   pending_positions [$];
  int          mismatches = 0;
  int          records_sent = 0;
  int          queries_sent = 0;
  int          positions_checked = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          long_hold_req = 1'b0;
  longint      track_time = 0;   // time base of the well-formed track

  function automatic longint clamp_unit(input longint v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  // cordic sine and cosine of a 2^32-per-turn angle, q2.30
  function automatic void rotate_unit(input logic [31:0] ang, output longint c,
                                      output longint s);
    logic [31:0] shifted;
    logic        flip;
    longint      x, y, z, nx;
    shifted = ang + 32'h4000_0000;
    flip = shifted[31];
    if (flip) ang = ang ^ 32'h8000_0000;
    z = longint'($signed(ang));
    x = 64'sh26DD3B6A;
    y = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ARCTAN[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ARCTAN[i];
      end
      x = nx;
    end
    x = clamp_unit(x);
    y = clamp_unit(y);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint mul_q30(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= r + bt) begin
        n = n - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  // linear blend of two ring slots, normalized; 0 when the blend vanishes
  function automatic bit blend_slots(input int unsigned later, input int unsigned earlier,
                                     input longint now, output vec3_t v);
    longint unsigned span, w, frac, sq, len, m;
    longint          sum, q;
    longint          b [3];
    int              sh;
    span = longint'(ring_time[later] - ring_time[earlier]);
    w    = longint'(now - ring_time[earlier]);
    sh = 0;
    sq = 0;
    while ((span >> sh) >= 64'h1_0000_0000) sh++;
    frac = ((w >> sh) << 32) / (span >> sh);
    for (int k = 0; k < 3; k++) begin
      sum = ring_vec[later][k] * longint'(frac)
          + ring_vec[earlier][k] * longint'((64'd1 << 32) - frac);
      b[k] = (sum + (64'sd1 <<< 31)) >>> 32;
      sq = sq + longint'(b[k] * b[k]);
    end
    if (sq == 0) return 1'b0;
    len = int_sqrt(sq);
    if (len == 0) return 1'b0;
    for (int k = 0; k < 3; k++) begin
      m = longint'(b[k] < 0 ? -b[k] : b[k]) << 30;
      q = longint'((m + len / 2) / len);
      v[k] = clamp_unit(b[k] < 0 ? -q : q);
    end
    return 1'b1;
  endfunction

  function automatic void store_sample(input logic [31:0] ra, input logic [31:0] dec,
                                       input longint t);
    longint cr, sr, cd, sd;
    ring_newest = (ring_newest + 1) % RING_SLOTS;
    rotate_unit(ra, cr, sr);
    rotate_unit(dec, cd, sd);
    ring_vec[ring_newest][0] = clamp_unit(mul_q30(cr, cd));
    ring_vec[ring_newest][1] = clamp_unit(mul_q30(sr, cd));
    ring_vec[ring_newest][2] = sd;
    ring_time[ring_newest] = t;
    ring_ok[ring_newest] = 1'b1;
  endfunction

  function automatic position_t interpolate_at(input longint t);
    position_t   r;
    vec3_t       v;
    longint      now;
    int unsigned p, pp;
    bit          done;
    r = '{x: '0, y: '0, z: '0, present: 1'b0};
    if (!ring_ok[ring_newest]) return r;
    now = t - delay_us;
    p = ring_newest;
    done = 1'b0;
    do begin
      pp = (p == 0) ? RING_SLOTS - 1 : p - 1;
      if (!ring_ok[pp]) break;
      if (ring_time[pp] <= now && now <= ring_time[p]) begin
        if (ring_time[pp] != ring_time[p]) done = blend_slots(p, pp, now, v);
        break;
      end
      p = pp;
    end while (p != ring_newest);
    if (!done) for (int k = 0; k < 3; k++) v[k] = ring_vec[p][k];
    r.x = v[0][31:0];
    r.y = v[1][31:0];
    r.z = v[2][31:0];
    r.present = 1'b1;
    return r;
  endfunction

  // offer one request, wait for its transfer, then update the ring copy or queue the expected position
  task automatic send_request(input logic kind, input logic [31:0] ra,
                              input logic [31:0] dec, input logic [62:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {1'b0, t, dec, ra};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (kind == REQ_RECORD) begin
      store_sample(ra, dec, longint'({1'b0, t}));
      records_sent++;
    end else begin
      pending_positions.push_back(interpolate_at(longint'({1'b0, t})));
      queries_sent++;
    end
  endtask

  // sender pause: drop valid, drain all results, let a trailing record finish
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_positions.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_delay(input logic [23:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    delay_us = longint'(value);
  endtask

  task automatic record_at(input logic [31:0] ra, input logic [31:0] dec, input longint t);
    send_request(REQ_RECORD, ra, dec, t[62:0]);
  endtask

  task automatic query_at(input longint t);
    send_request(REQ_QUERY, $urandom, $urandom, t[62:0]);
  endtask

  // extremes of angles and times plus corners of the ring walk
  task automatic test_directed();
    query_at(0);                                       // empty history
    query_at(TIME_TOP);
    record_at(32'h0000_0000, 32'h0000_0000, 10000);    // +x
    record_at(32'h8000_0000, 32'h0000_0000, 20000);    // -x, antipodal
    query_at(15000 + 1);                               // blend vanishes, later sample
    query_at(12500 + 1);
    query_at(0);                                       // query time below the delay
    query_at(500);                                     // before oldest, walk hits empty slot
    query_at(90000);                                   // after newest
    record_at(32'hFFFF_FFFF, 32'h7FFF_FFFF, 30000);
    record_at(32'h4000_0000, 32'h8000_0000, 30000);    // equal bracket times
    query_at(30000 + 1);
    record_at(32'hC000_0000, 32'h4000_0000, 45000);
    record_at(32'h5555_5555, 32'hAAAA_AAAA, 60000);
    query_at(52000 + 1);
    query_at(45000 + 1);                               // exactly on a sample
    record_at(32'h1234_5678, 32'hC000_0000, TIME_TOP); // largest timestamp
    query_at(TIME_TOP);
    query_at(64'h4000_0000_0000_0000);                 // huge span, shifted weight
    track_time = 0;
  endtask

  // mostly a well-formed track with queries around it, some noise
  task automatic run_track(input int count);
    int     r;
    longint t;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 40) begin
        track_time = track_time + ((r < 4) ? 0 : $urandom_range(1, 1000000));
        record_at($urandom, $urandom, track_time);
      end else if (r < 80) begin
        t = track_time - longint'($urandom_range(0, 9000000)) + delay_us;
        query_at(t < 0 ? 0 : t);
      end else if (r < 90) begin
        query_at(track_time + longint'($urandom_range(0, 3000000)));
      end else begin
        t = longint'({1'b0, $urandom, $urandom}) & 64'h7FFF_FFFF_FFFF_FFFF;
        if (t > TIME_TOP) t = TIME_TOP;
        if (r < 95) record_at($urandom, $urandom, t);
        else query_at(t);
      end
    end
  endtask

  task automatic test_no_idling();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_delay(DELAY_NOM);
    run_track(130);
  endtask

  task automatic test_sender_idle();
    send_idle_pct = 50;
    recv_stall_pct = 0;
    write_delay(DELAY_MAX);
    run_track(130);
  endtask

  task automatic test_receiver_stall();
    send_idle_pct = 0;
    recv_stall_pct = 50;
    write_delay(DELAY_MIN);
    run_track(130);
  endtask

  task automatic test_both_idle();
    send_idle_pct = 12;
    recv_stall_pct = 12;
    write_delay(24'($urandom_range(1, 16777215)));
    run_track(120);
  endtask

  // receiver holds off for a long stretch while queries keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_hold_req = 1'b1;
    for (int i = 0; i < 8; i++) query_at(track_time + delay_us);
    drain_results();
  endtask

  // receiver side: random stalls plus the long hold-off
  int hold_left = 0;
  always @(posedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker: each transfer against the oldest pending position
  always @(posedge clk) begin
    position_t exp_pos;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_positions.size() == 0) begin
        $error("result transfer with no query outstanding");
        mismatches++;
      end else begin
        exp_pos = pending_positions.pop_front();
        positions_checked++;
        if (m_tdata[31:0] !== exp_pos.x) begin
          $error("pos_x expected %h got %h", exp_pos.x, m_tdata[31:0]);
          mismatches++;
        end
        if (m_tdata[63:32] !== exp_pos.y) begin
          $error("pos_y expected %h got %h", exp_pos.y, m_tdata[63:32]);
          mismatches++;
        end
        if (m_tdata[95:64] !== exp_pos.z) begin
          $error("pos_z expected %h got %h", exp_pos.z, m_tdata[95:64]);
          mismatches++;
        end
        if (m_tuser !== exp_pos.present) begin
          $error("history_present expected %b got %b", exp_pos.present, m_tuser);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (!rst) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", quiet_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < RING_SLOTS; i++) begin
      ring_vec[i] = '{0, 0, 0};
      ring_time[i] = 0;
      ring_ok[i] = 1'b0;
    end
    ring_newest = 0;
    delay_us = 1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_no_idling();
    test_backpressure();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    drain_results();
    $display("covered %0d records and %0d queries, %0d positions checked",
             records_sent, queries_sent, positions_checked);
    $display("delays from 1 us to full scale, ring wrap, empty and unbracketed walks");
    if (mismatches == 0 && pending_positions.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
